### rtl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// Depends on nothing; used by every module of the block.
package ffra_pkg;

    localparam int REGION_BYTES = 16384;
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = 14;
    localparam int SIZE_W       = 15;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_OVERLAP = 2'd2,
        STAT_FULL    = 2'd3
    } stat_t;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] len;
    } seg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_READ,
        OP_SKIP,
        OP_TRIM,
        OP_STATUS,
        OP_JOIN_BOTH,
        OP_JOIN_PREV,
        OP_JOIN_NEXT,
        OP_DROP_RD,
        OP_DROP_WR,
        OP_DEC,
        OP_INS_START,
        OP_INS_RD,
        OP_INS_WR
    } dp_op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_R_CHK0,
        S_R_RD,
        S_R_CHK,
        S_R_MERGE,
        S_DROP_RD,
        S_DROP_WR,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
        stat_t  stat;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_release;
        logic idx_lt_count;
        logic fits;
        logic trim_empty;
        logic size_zero;
        logic range_bad;
        logic lies_below;
        logic overlap;
        logic join_prev;
        logic join_next;
        logic table_full;
        logic drop_more;
        logic ins_more;
    } dp_status_t;

endpackage

### rtl/ffra_datapath.sv
// Datapath: free-segment table memory, walk pointers, request and result registers.
// Depends on ffra_pkg; driven by ffra_ctrl through dp_cmd_t.
module ffra_datapath import ffra_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          stat,
    input  logic                in_func,
    input  logic [SIZE_W-1:0]   in_size,
    input  logic [ADDR_W-1:0]   in_addr,
    output logic [ADDR_W-1:0]   out_granted,
    output logic [1:0]          out_status
);

    seg_t              mem [MAX_SEGMENTS];
    seg_t              rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    seg_t              wr_data;

    logic              func_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    seg_t              prev_reg;
    logic [ADDR_W-1:0] granted_reg;
    stat_t             res_reg;
    logic [ADDR_W-1:0] out_granted_reg;
    logic [1:0]        out_status_reg;

    logic [SIZE_W:0]   end_val;
    logic [SIZE_W:0]   rd_end;
    logic [SIZE_W:0]   prev_end;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_m1;
    logic [IDX_W-1:0]  ptr_m1;
    logic [IDX_W-1:0]  idx_p1;

    // Derived values
    assign end_val  = {2'b0, addr_reg} + {1'b0, size_reg};
    assign rd_end   = {2'b0, rd_reg.start} + {1'b0, rd_reg.len};
    assign prev_end = {2'b0, prev_reg.start} + {1'b0, prev_reg.len};
    assign idx_a    = idx_reg[IDX_W-1:0];
    assign idx_m1   = idx_a - IDX_W'(1);
    assign idx_p1   = idx_a + IDX_W'(1);
    assign ptr_m1   = ptr_reg[IDX_W-1:0] - IDX_W'(1);

    // Status to controller
    always_comb begin
        stat.is_release   = (func_reg == FUNC_RELEASE);
        stat.idx_lt_count = (idx_reg < count_reg);
        stat.fits         = (rd_reg.len >= size_reg);
        stat.trim_empty   = (rd_reg.len == size_reg);
        stat.size_zero    = (size_reg == '0);
        stat.range_bad    = (end_val > (SIZE_W+1)'(REGION_BYTES));
        stat.lies_below   = (end_val <= {2'b0, rd_reg.start});
        stat.overlap      = (rd_end > {2'b0, addr_reg});
        stat.join_prev    = (idx_reg != '0) && (prev_end == {2'b0, addr_reg});
        stat.join_next    = (idx_reg < count_reg) && ({2'b0, rd_reg.start} == end_val);
        stat.table_full   = (count_reg >= CNT_W'(MAX_SEGMENTS));
        stat.drop_more    = ((idx_reg + CNT_W'(1)) < count_reg);
        stat.ins_more     = (ptr_reg > idx_reg);
    end

    // Memory port selection and pointer updates
    always_comb begin
        rd_addr    = idx_a;
        wr_en      = 1'b0;
        wr_addr    = idx_a;
        wr_data    = rd_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        case (cmd.op)
            OP_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{start: '0, len: SIZE_W'(REGION_BYTES)};
                count_next = CNT_W'(1);
            end
            OP_LOAD: begin
                idx_next = '0;
            end
            OP_SKIP: begin
                idx_next = idx_reg + CNT_W'(1);
            end
            OP_TRIM: begin
                wr_en   = 1'b1;
                wr_data = '{start: ADDR_W'({1'b0, rd_reg.start} + size_reg),
                            len:   rd_reg.len - size_reg};
            end
            OP_JOIN_BOTH: begin
                wr_en   = 1'b1;
                wr_addr = idx_m1;
                wr_data = '{start: prev_reg.start,
                            len:   prev_reg.len + size_reg + rd_reg.len};
            end
            OP_JOIN_PREV: begin
                wr_en   = 1'b1;
                wr_addr = idx_m1;
                wr_data = '{start: prev_reg.start, len: prev_reg.len + size_reg};
            end
            OP_JOIN_NEXT: begin
                wr_en   = 1'b1;
                wr_data = '{start: addr_reg, len: rd_reg.len + size_reg};
            end
            OP_DROP_RD: begin
                rd_addr = idx_p1;
            end
            OP_DROP_WR: begin
                wr_en    = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
            end
            OP_DEC: begin
                count_next = count_reg - CNT_W'(1);
            end
            OP_INS_START: begin
                ptr_next = count_reg;
            end
            OP_INS_RD: begin
                rd_addr = ptr_m1;
            end
            OP_INS_WR: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                ptr_next = ptr_reg - CNT_W'(1);
            end
            default: begin
            end
        endcase
        // new entry goes in at the sorted place once the shift is done
        if (cmd.out_load == 1'b0 && cmd.op == OP_NONE && cmd.stat == STAT_FULL) begin
            wr_en      = 1'b1;
            wr_data    = '{start: addr_reg, len: size_reg};
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Request, walk and result payload
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            func_reg    <= in_func;
            size_reg    <= in_size;
            addr_reg    <= in_addr;
            granted_reg <= '0;
            res_reg     <= STAT_OK;
        end
        if (cmd.op == OP_SKIP) begin
            prev_reg <= rd_reg;
        end
        if (cmd.op == OP_TRIM) begin
            granted_reg <= rd_reg.start;
        end
        if (cmd.op == OP_STATUS) begin
            res_reg <= cmd.stat;
        end
        if (cmd.out_load) begin
            out_granted_reg <= granted_reg;
            out_status_reg  <= res_reg;
        end
    end

    assign out_granted = out_granted_reg;
    assign out_status  = out_status_reg;

endmodule

### rtl/ffra_ctrl.sv
// Controller: sequences table walks, merges and shifts; owns the result valid flag.
// Depends on ffra_pkg; commands ffra_datapath.
module ffra_ctrl import ffra_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '{op: OP_NONE, stat: STAT_OK, out_load: 1'b0};
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_A_RD;
                end
            end
            S_A_RD: begin
                if (stat.is_release) begin
                    state_next = S_R_CHK0;
                end else if (stat.idx_lt_count) begin
                    cmd.op     = OP_READ;
                    state_next = S_A_CHK;
                end else begin
                    cmd.op     = OP_STATUS;
                    cmd.stat   = STAT_NOFIT;
                    state_next = S_DONE;
                end
            end
            S_A_CHK: begin
                if (stat.fits) begin
                    cmd.op     = OP_TRIM;
                    state_next = stat.trim_empty ? S_DROP_RD : S_DONE;
                end else begin
                    cmd.op     = OP_SKIP;
                    state_next = S_A_RD;
                end
            end
            S_R_CHK0: begin
                if (stat.size_zero) begin
                    state_next = S_DONE;
                end else if (stat.range_bad) begin
                    cmd.op     = OP_STATUS;
                    cmd.stat   = STAT_OVERLAP;
                    state_next = S_DONE;
                end else begin
                    state_next = S_R_RD;
                end
            end
            S_R_RD: begin
                if (stat.idx_lt_count) begin
                    cmd.op     = OP_READ;
                    state_next = S_R_CHK;
                end else begin
                    state_next = S_R_MERGE;
                end
            end
            S_R_CHK: begin
                if (stat.lies_below) begin
                    state_next = S_R_MERGE;
                end else if (stat.overlap) begin
                    cmd.op     = OP_STATUS;
                    cmd.stat   = STAT_OVERLAP;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SKIP;
                    state_next = S_R_RD;
                end
            end
            S_R_MERGE: begin
                if (stat.join_prev && stat.join_next) begin
                    cmd.op     = OP_JOIN_BOTH;
                    state_next = S_DROP_RD;
                end else if (stat.join_prev) begin
                    cmd.op     = OP_JOIN_PREV;
                    state_next = S_DONE;
                end else if (stat.join_next) begin
                    cmd.op     = OP_JOIN_NEXT;
                    state_next = S_DONE;
                end else if (stat.table_full) begin
                    cmd.op     = OP_STATUS;
                    cmd.stat   = STAT_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_INS_START;
                    state_next = S_INS_RD;
                end
            end
            // close the gap left by an emptied entry
            S_DROP_RD: begin
                if (stat.drop_more) begin
                    cmd.op     = OP_DROP_RD;
                    state_next = S_DROP_WR;
                end else begin
                    cmd.op     = OP_DEC;
                    state_next = S_DONE;
                end
            end
            S_DROP_WR: begin
                cmd.op     = OP_DROP_WR;
                state_next = S_DROP_RD;
            end
            // open a slot at the sorted place, top entry first
            S_INS_RD: begin
                if (stat.ins_more) begin
                    cmd.op     = OP_INS_RD;
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_WR: begin
                cmd.op     = OP_INS_WR;
                state_next = S_INS_RD;
            end
            S_INS_PUT: begin
                // put-new-entry command: no op, full code, no load
                cmd.stat   = STAT_FULL;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/first_fit_region_allocator_core.sv
// Top level of the first-fit region allocator with coalescing.
// Depends on ffra_pkg, ffra_ctrl and ffra_datapath.
//
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_func, s_request_size, s_block_address
// m_      | out       | m_valid / m_ready  | m_granted_address, m_status
//
// One request at a time. The free table sits in a single memory with a
// registered read, so each entry visited in a walk takes a read state and a
// check state; a shift on removal or insertion takes a read state and a write
// state per entry moved. After a result is loaded the controller returns to
// S_IDLE before the next transfer. After reset S_INIT writes the initial
// segment before s_ready rises. A result waiting on m_ready does not block the
// next transfer; only the load of the following result waits for it.
module first_fit_region_allocator_core import ffra_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [SIZE_W-1:0] s_request_size,
    input  logic [ADDR_W-1:0] s_block_address,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_granted_address,
    output logic [1:0]        m_status
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    ffra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffra_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_func     (s_func),
        .in_size     (s_request_size),
        .in_addr     (s_block_address),
        .out_granted (m_granted_address),
        .out_status  (m_status)
    );

endmodule

### rtl/ffra_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on ffra_pkg.
module ffra_checker import ffra_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [ADDR_W-1:0] m_granted_address,
    input logic [1:0]        m_status
);

    // result held while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_address) && $stable(m_status))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    // failures grant nothing
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_granted_address == '0)
        else $error("address granted on failure");

    // no ready or valid while the table is set up after reset
    a_init: assert property (@(posedge aclk)
        !$past(aresetn) && aresetn |-> !s_ready && !m_valid)
        else $error("ready or valid right after reset");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_granted_address (m_granted_address),
    .m_status          (m_status)
);
